// ----- src/stq_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, micro-operation codes and controller/datapath structs for the timer queue.
package stq_pkg;

  localparam int POOL        = 256;
  localparam int ID_W        = 8;
  localparam int CNT_W       = 9;
  localparam int TIME_W      = 63;
  localparam int TO_W        = 32;
  localparam int LINE_SIZE   = 16;
  localparam int LINES       = 16;
  localparam int MAX_RESULTS = 16;
  localparam int CHK_LIMIT   = (LINES < MAX_RESULTS) ? LINES : MAX_RESULTS;
  localparam int LINES_W     = $clog2(LINES + 1);
  localparam int IDX_W       = $clog2(LINE_SIZE + 1);
  localparam int CHK_W       = $clog2(CHK_LIMIT + 1);
  localparam int BASE_W      = $clog2((LINES + 1) * LINE_SIZE + 1);
  localparam int S_TDATA_W   = 104;
  localparam int M_TDATA_W   = 8;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam logic [2:0] MODE_ADD    = 3'd0;
  localparam logic [2:0] MODE_UPDATE = 3'd1;
  localparam logic [2:0] MODE_DELETE = 3'd2;
  localparam logic [2:0] MODE_CHECK  = 3'd3;
  localparam logic [2:0] MODE_RESET  = 3'd4;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_EXPIRED = 2'd2;
  localparam logic [1:0] ST_NONE    = 2'd3;

  typedef enum logic [4:0] {
    UOP_NONE,
    UOP_LOAD,
    UOP_POP_RD,
    UOP_POP,
    UOP_LINE_OPEN,
    UOP_LINE_PUSH,
    UOP_ACTIVATE,
    UOP_UNL_RD,
    UOP_UNL_WR,
    UOP_ENQ_START,
    UOP_WALK_NEXT,
    UOP_INS1,
    UOP_INS2,
    UOP_APPEND,
    UOP_FREE,
    UOP_CHK_RD,
    UOP_CHK_POP,
    UOP_RST_RD,
    UOP_RST_STEP
  } uop_t;

  typedef enum logic [1:0] {
    IDSEL_ZERO,
    IDSEL_TIMER,
    IDSEL_PEND
  } id_sel_t;

  typedef struct packed {
    uop_t       uop;
    logic       emit;
    logic [1:0] st;
    id_sel_t    id_sel;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       timeout_zero;
    logic       stack_empty;
    logic       line_full;
    logic       line_done;
    logic       active;
    logic       queued;
    logic       qlen_zero;
    logic       cur_is_tail;
    logic       exp_gt;
    logic       exp_lt;
    logic       chk_done;
    logic       pend_valid;
    logic       out_free;
  } stat_t;

endpackage

// ----- src/stq_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module stq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/stq_datapath.sv -----
`timescale 1ns / 1ps
// Timer queue datapath: linked-list memories, free stack, flags and result register.
module stq_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  stq_pkg::cmd_t                   cmd,
  output stq_pkg::stat_t                  stat,
  input  logic [2:0]                      in_mode,
  input  logic [stq_pkg::ID_W-1:0]        in_id,
  input  logic [stq_pkg::TO_W-1:0]        in_timeout,
  input  logic [stq_pkg::TIME_W-1:0]      in_now,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_status,
  output logic [stq_pkg::ID_W-1:0]        out_id,
  output logic                            out_last
);

  logic [2:0]                   mode_r;
  logic [stq_pkg::ID_W-1:0]     id_r;
  logic                         tzero_r;
  logic [stq_pkg::TIME_W-1:0]   t_r;
  logic [stq_pkg::TIME_W-1:0]   now_r;
  logic [stq_pkg::ID_W-1:0]     head;
  logic [stq_pkg::ID_W-1:0]     tail;
  logic [stq_pkg::ID_W-1:0]     cur;
  logic [stq_pkg::CNT_W-1:0]    qlen;
  logic [stq_pkg::CNT_W-1:0]    fc;
  logic [stq_pkg::LINES_W-1:0]  lines;
  logic [stq_pkg::IDX_W-1:0]    idx;
  logic [stq_pkg::ID_W-1:0]     pend_id;
  logic                         pend_valid;
  logic [stq_pkg::CHK_W-1:0]    chk_n;
  logic [stq_pkg::POOL-1:0]     active;
  logic [stq_pkg::POOL-1:0]     queued;

  logic [stq_pkg::TIME_W:0]     sum;
  logic [stq_pkg::BASE_W-1:0]   base;
  logic                         out_free;

  logic                         rd_en;
  logic [stq_pkg::ID_W-1:0]     rd_addr;
  logic [stq_pkg::ID_W-1:0]     next_rdata;
  logic [stq_pkg::ID_W-1:0]     prev_rdata;
  logic [stq_pkg::TIME_W-1:0]   exp_rdata;
  logic                         next_we;
  logic [stq_pkg::ID_W-1:0]     next_waddr;
  logic [stq_pkg::ID_W-1:0]     next_wdata;
  logic                         prev_we;
  logic [stq_pkg::ID_W-1:0]     prev_waddr;
  logic [stq_pkg::ID_W-1:0]     prev_wdata;
  logic                         exp_we;
  logic                         push_en;
  logic                         push_ok;
  logic [stq_pkg::ID_W-1:0]     push_val;
  logic                         stk_re;
  logic [stq_pkg::ID_W-1:0]     stk_rdata;
  logic [stq_pkg::ID_W-1:0]     stk_raddr;

  assign sum      = {1'b0, in_now} + {{(stq_pkg::TIME_W + 1 - stq_pkg::TO_W){1'b0}}, in_timeout};
  assign base     = stq_pkg::BASE_W'(lines) * stq_pkg::BASE_W'(stq_pkg::LINE_SIZE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    stat.mode         = mode_r;
    stat.timeout_zero = tzero_r;
    stat.stack_empty  = (fc == '0);
    stat.line_full    = (lines >= stq_pkg::LINES_W'(stq_pkg::LINES)) ||
                        (base + stq_pkg::BASE_W'(stq_pkg::LINE_SIZE) >
                         stq_pkg::BASE_W'(stq_pkg::POOL));
    stat.line_done    = (idx == stq_pkg::IDX_W'(stq_pkg::LINE_SIZE));
    stat.active       = active[id_r];
    stat.queued       = queued[id_r];
    stat.qlen_zero    = (qlen == '0);
    stat.cur_is_tail  = (cur == tail);
    stat.exp_gt       = (exp_rdata > t_r);
    stat.exp_lt       = (exp_rdata < now_r);
    stat.chk_done     = (chk_n == stq_pkg::CHK_W'(stq_pkg::CHK_LIMIT));
    stat.pend_valid   = pend_valid;
    stat.out_free     = out_free;
  end

  // Shared read address for the next, prev and expiry memories.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = head;
    unique case (cmd.uop) inside
      stq_pkg::UOP_ENQ_START, stq_pkg::UOP_CHK_RD, stq_pkg::UOP_RST_RD: begin
        rd_en   = 1'b1;
        rd_addr = head;
      end
      stq_pkg::UOP_WALK_NEXT, stq_pkg::UOP_RST_STEP: begin
        rd_en   = 1'b1;
        rd_addr = next_rdata;
      end
      stq_pkg::UOP_UNL_RD: begin
        rd_en   = 1'b1;
        rd_addr = id_r;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    next_we    = 1'b0;
    next_waddr = id_r;
    next_wdata = cur;
    prev_we    = 1'b0;
    prev_waddr = cur;
    prev_wdata = id_r;
    unique case (cmd.uop)
      stq_pkg::UOP_INS1: begin
        next_we    = 1'b1;
        next_waddr = id_r;
        next_wdata = cur;
        prev_we    = 1'b1;
        prev_waddr = cur;
        prev_wdata = id_r;
      end
      stq_pkg::UOP_INS2: begin
        next_we    = (cur != head);
        next_waddr = prev_rdata;
        next_wdata = id_r;
        prev_we    = 1'b1;
        prev_waddr = id_r;
        prev_wdata = prev_rdata;
      end
      stq_pkg::UOP_APPEND: begin
        next_we    = (qlen != '0);
        next_waddr = tail;
        next_wdata = id_r;
        prev_we    = (qlen != '0);
        prev_waddr = id_r;
        prev_wdata = tail;
      end
      stq_pkg::UOP_UNL_WR: begin
        next_we    = (id_r != head);
        next_waddr = prev_rdata;
        next_wdata = next_rdata;
        prev_we    = (id_r != tail);
        prev_waddr = next_rdata;
        prev_wdata = prev_rdata;
      end
      default: begin
        next_we = 1'b0;
      end
    endcase
  end

  assign exp_we = (cmd.uop == stq_pkg::UOP_ENQ_START);

  always_comb begin
    push_en  = 1'b0;
    push_val = id_r;
    unique case (cmd.uop)
      stq_pkg::UOP_LINE_PUSH: begin
        push_en  = 1'b1;
        push_val = id_r + stq_pkg::ID_W'(idx);
      end
      stq_pkg::UOP_FREE: begin
        push_en  = 1'b1;
        push_val = id_r;
      end
      stq_pkg::UOP_RST_STEP: begin
        push_en  = 1'b1;
        push_val = cur;
      end
      default: begin
        push_en = 1'b0;
      end
    endcase
  end

  assign push_ok   = push_en && (fc < stq_pkg::CNT_W'(stq_pkg::POOL));
  assign stk_re    = (cmd.uop == stq_pkg::UOP_POP_RD);
  assign stk_raddr = stq_pkg::ID_W'(fc - 1'b1);

  stq_ram #(.WIDTH(stq_pkg::ID_W), .DEPTH(stq_pkg::POOL)) u_next (
    .clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
    .re(rd_en), .raddr(rd_addr), .rdata(next_rdata)
  );

  stq_ram #(.WIDTH(stq_pkg::ID_W), .DEPTH(stq_pkg::POOL)) u_prev (
    .clk(clk), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
    .re(rd_en), .raddr(rd_addr), .rdata(prev_rdata)
  );

  stq_ram #(.WIDTH(stq_pkg::TIME_W), .DEPTH(stq_pkg::POOL)) u_exp (
    .clk(clk), .we(exp_we), .waddr(id_r), .wdata(t_r),
    .re(rd_en), .raddr(rd_addr), .rdata(exp_rdata)
  );

  stq_ram #(.WIDTH(stq_pkg::ID_W), .DEPTH(stq_pkg::POOL)) u_stack (
    .clk(clk), .we(push_ok), .waddr(stq_pkg::ID_W'(fc)), .wdata(push_val),
    .re(stk_re), .raddr(stk_raddr), .rdata(stk_rdata)
  );

  // Payload registers
  always_ff @(posedge clk) begin
    unique case (cmd.uop) inside
      stq_pkg::UOP_LOAD: begin
        mode_r  <= in_mode;
        id_r    <= in_id;
        tzero_r <= (in_timeout == '0);
        now_r   <= in_now;
        t_r     <= sum[stq_pkg::TIME_W] ? stq_pkg::TIME_MAX : sum[stq_pkg::TIME_W-1:0];
      end
      stq_pkg::UOP_POP: begin
        id_r <= stk_rdata;
      end
      stq_pkg::UOP_LINE_OPEN: begin
        id_r <= stq_pkg::ID_W'(base);
        idx  <= stq_pkg::IDX_W'(1);
      end
      stq_pkg::UOP_LINE_PUSH: begin
        idx <= idx + 1'b1;
      end
      stq_pkg::UOP_ENQ_START, stq_pkg::UOP_RST_RD: begin
        cur <= head;
      end
      stq_pkg::UOP_WALK_NEXT, stq_pkg::UOP_RST_STEP: begin
        cur <= next_rdata;
      end
      stq_pkg::UOP_CHK_POP: begin
        pend_id <= head;
      end
      default: begin
        cur <= cur;
      end
    endcase
    if (cmd.emit) begin
      out_status <= cmd.st;
      out_last   <= cmd.last;
      unique case (cmd.id_sel)
        stq_pkg::IDSEL_TIMER: out_id <= id_r;
        stq_pkg::IDSEL_PEND:  out_id <= pend_id;
        default:              out_id <= '0;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      qlen       <= '0;
      fc         <= '0;
      lines      <= '0;
      pend_valid <= 1'b0;
      chk_n      <= '0;
      active     <= '0;
      queued     <= '0;
      out_valid  <= 1'b0;
      head       <= '0;
      tail       <= '0;
    end else begin
      if (push_ok) begin
        fc <= fc + 1'b1;
      end
      unique case (cmd.uop)
        stq_pkg::UOP_LOAD: begin
          pend_valid <= 1'b0;
          chk_n      <= '0;
        end
        stq_pkg::UOP_POP: begin
          fc <= fc - 1'b1;
        end
        stq_pkg::UOP_LINE_OPEN: begin
          lines <= lines + 1'b1;
        end
        stq_pkg::UOP_ACTIVATE: begin
          active[id_r] <= 1'b1;
        end
        stq_pkg::UOP_UNL_WR: begin
          if (id_r == head) begin
            head <= next_rdata;
          end
          if (id_r == tail) begin
            tail <= prev_rdata;
          end
          qlen         <= qlen - 1'b1;
          queued[id_r] <= 1'b0;
        end
        stq_pkg::UOP_INS2: begin
          if (cur == head) begin
            head <= id_r;
          end
          qlen         <= qlen + 1'b1;
          queued[id_r] <= 1'b1;
        end
        stq_pkg::UOP_APPEND: begin
          if (qlen == '0) begin
            head <= id_r;
          end
          tail         <= id_r;
          qlen         <= qlen + 1'b1;
          queued[id_r] <= 1'b1;
        end
        stq_pkg::UOP_FREE: begin
          active[id_r] <= 1'b0;
        end
        stq_pkg::UOP_CHK_POP: begin
          head         <= next_rdata;
          qlen         <= qlen - 1'b1;
          queued[head] <= 1'b0;
          pend_valid   <= 1'b1;
          chk_n        <= chk_n + 1'b1;
        end
        stq_pkg::UOP_RST_STEP: begin
          active[cur] <= 1'b0;
          queued[cur] <= 1'b0;
          qlen        <= qlen - 1'b1;
        end
        default: begin
          qlen <= qlen;
        end
      endcase
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- src/stq_ctrl.sv -----
`timescale 1ns / 1ps
// Timer queue controller: sequences add, update, delete, check and reset operations.
module stq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  stq_pkg::stat_t stat,
  output stq_pkg::cmd_t  cmd
);

  typedef enum logic [17:0] {
    S_IDLE     = 18'h00001,
    S_DISPATCH = 18'h00002,
    S_ADD_POP  = 18'h00004,
    S_ADD_LINE = 18'h00008,
    S_ADD_ACT  = 18'h00010,
    S_UNL      = 18'h00020,
    S_UNL_WR   = 18'h00040,
    S_ENQ      = 18'h00080,
    S_ENQ_APP  = 18'h00100,
    S_WALK     = 18'h00200,
    S_INS2     = 18'h00400,
    S_FREE     = 18'h00800,
    S_CHK_RD   = 18'h01000,
    S_CHK_CMP  = 18'h02000,
    S_CHK_FIN  = 18'h04000,
    S_RST_LOOP = 18'h08000,
    S_REPORT   = 18'h10000,
    S_REFUSE   = 18'h20000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.uop    = stq_pkg::UOP_NONE;
    cmd.emit   = 1'b0;
    cmd.st     = stq_pkg::ST_DONE;
    cmd.id_sel = stq_pkg::IDSEL_ZERO;
    cmd.last   = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.uop    = stq_pkg::UOP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat.mode) inside
          stq_pkg::MODE_ADD: begin
            if (stat.timeout_zero) begin
              state_next = S_REFUSE;
            end else if (!stat.stack_empty) begin
              cmd.uop    = stq_pkg::UOP_POP_RD;
              state_next = S_ADD_POP;
            end else if (stat.line_full) begin
              state_next = S_REFUSE;
            end else begin
              cmd.uop    = stq_pkg::UOP_LINE_OPEN;
              state_next = S_ADD_LINE;
            end
          end
          stq_pkg::MODE_UPDATE, stq_pkg::MODE_DELETE: begin
            if (!stat.active) begin
              state_next = S_REFUSE;
            end else if (stat.queued) begin
              state_next = S_UNL;
            end else if (stat.mode == stq_pkg::MODE_DELETE) begin
              state_next = S_FREE;
            end else begin
              state_next = S_ENQ;
            end
          end
          stq_pkg::MODE_CHECK: begin
            state_next = S_CHK_RD;
          end
          stq_pkg::MODE_RESET: begin
            cmd.uop    = stq_pkg::UOP_RST_RD;
            state_next = S_RST_LOOP;
          end
          default: begin
            state_next = S_REFUSE;
          end
        endcase
      end
      S_ADD_POP: begin
        cmd.uop    = stq_pkg::UOP_POP;
        state_next = S_ADD_ACT;
      end
      S_ADD_LINE: begin
        // push the rest of the new line, lowest id first
        if (stat.line_done) begin
          state_next = S_ADD_ACT;
        end else begin
          cmd.uop = stq_pkg::UOP_LINE_PUSH;
        end
      end
      S_ADD_ACT: begin
        cmd.uop    = stq_pkg::UOP_ACTIVATE;
        state_next = S_ENQ;
      end
      S_UNL: begin
        cmd.uop    = stq_pkg::UOP_UNL_RD;
        state_next = S_UNL_WR;
      end
      S_UNL_WR: begin
        cmd.uop    = stq_pkg::UOP_UNL_WR;
        state_next = (stat.mode == stq_pkg::MODE_DELETE) ? S_FREE : S_ENQ;
      end
      S_ENQ: begin
        cmd.uop    = stq_pkg::UOP_ENQ_START;
        state_next = stat.qlen_zero ? S_ENQ_APP : S_WALK;
      end
      S_ENQ_APP: begin
        cmd.uop    = stq_pkg::UOP_APPEND;
        state_next = S_REPORT;
      end
      S_WALK: begin
        // insert before the first entry that expires later; ties stay ahead
        if (stat.exp_gt) begin
          cmd.uop    = stq_pkg::UOP_INS1;
          state_next = S_INS2;
        end else if (stat.cur_is_tail) begin
          cmd.uop    = stq_pkg::UOP_APPEND;
          state_next = S_REPORT;
        end else begin
          cmd.uop = stq_pkg::UOP_WALK_NEXT;
        end
      end
      S_INS2: begin
        cmd.uop    = stq_pkg::UOP_INS2;
        state_next = S_REPORT;
      end
      S_FREE: begin
        cmd.uop    = stq_pkg::UOP_FREE;
        state_next = S_REPORT;
      end
      S_CHK_RD: begin
        if (stat.chk_done || stat.qlen_zero) begin
          state_next = S_CHK_FIN;
        end else begin
          cmd.uop    = stq_pkg::UOP_CHK_RD;
          state_next = S_CHK_CMP;
        end
      end
      S_CHK_CMP: begin
        // hold each popped id until the next compare tells whether it is the last beat
        if (!stat.exp_lt) begin
          state_next = S_CHK_FIN;
        end else if (!stat.pend_valid || stat.out_free) begin
          cmd.uop    = stq_pkg::UOP_CHK_POP;
          cmd.emit   = stat.pend_valid;
          cmd.st     = stq_pkg::ST_EXPIRED;
          cmd.id_sel = stq_pkg::IDSEL_PEND;
          cmd.last   = 1'b0;
          state_next = S_CHK_RD;
        end
      end
      S_CHK_FIN: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.st     = stat.pend_valid ? stq_pkg::ST_EXPIRED : stq_pkg::ST_NONE;
          cmd.id_sel = stat.pend_valid ? stq_pkg::IDSEL_PEND : stq_pkg::IDSEL_ZERO;
          state_next = S_IDLE;
        end
      end
      S_RST_LOOP: begin
        if (stat.qlen_zero) begin
          state_next = S_REPORT;
        end else begin
          cmd.uop = stq_pkg::UOP_RST_STEP;
        end
      end
      S_REPORT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.st     = stq_pkg::ST_DONE;
          cmd.id_sel = (stat.mode == stq_pkg::MODE_ADD) ? stq_pkg::IDSEL_TIMER
                                                       : stq_pkg::IDSEL_ZERO;
          state_next = S_IDLE;
        end
      end
      S_REFUSE: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.st     = stq_pkg::ST_REFUSED;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- src/sorted_timer_queue_top.sv -----
`timescale 1ns / 1ps
// Add/update walk past queued timers on insert; a new id line pushes the rest of its ids onto
// the free stack; check pops expired timers one by one; reset queue steps through each queued
// timer. One item is in work at a time; the result register lets the next beat be accepted
// while the last result waits.
// rst is synchronous and empties the queue, the free stack and every id flag.
module sorted_timer_queue_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [stq_pkg::S_TDATA_W-1:0]     s_tdata,  // timer_id, timeout, now, pad
  input  logic [2:0]                        s_tuser,  // mode
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [stq_pkg::M_TDATA_W-1:0]     m_tdata,  // result_id
  output logic [1:0]                        m_tuser,  // status
  output logic                              m_tlast
);

  stq_pkg::cmd_t  cmd;
  stq_pkg::stat_t stat;

  stq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  stq_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_mode   (s_tuser),
    .in_id     (s_tdata[7:0]),
    .in_timeout(s_tdata[39:8]),
    .in_now    (s_tdata[102:40]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_status(m_tuser),
    .out_id    (m_tdata),
    .out_last  (m_tlast)
  );

endmodule
